// ===== rtl/dcts_pkg.sv =====
package dcts_pkg;

    // sizes
    localparam int TASKS       = 64;
    localparam int EXTRA_SLOTS = 8;
    localparam int TIDX_W      = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int SLOT_W      = (EXTRA_SLOTS > 1) ? $clog2(EXTRA_SLOTS) : 1;
    localparam int WIDX_W      = $clog2(TASKS + 1);
    localparam int READY_W     = 7;
    localparam logic [READY_W-1:0] READY_MAX = 7'd127;

    // action codes
    localparam logic [3:0] ACT_LOAD_TASK = 4'd0;
    localparam logic [3:0] ACT_LOAD_EDGE = 4'd1;
    localparam logic [3:0] ACT_FINALIZE  = 4'd2;
    localparam logic [3:0] ACT_ADD_EXTRA = 4'd3;
    localparam logic [3:0] ACT_INST      = 4'd4;
    localparam logic [3:0] ACT_INST_PEND = 4'd5;
    localparam logic [3:0] ACT_TASK_DONE = 4'd6;
    localparam logic [3:0] ACT_RECEIVE   = 4'd7;
    localparam logic [3:0] ACT_NOTIFY    = 4'd8;

    // result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_READY = 2'd1;
    localparam logic [1:0] KIND_DEFER = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    typedef struct packed {
        logic [3:0]  action;
        logic [5:0]  task_req;
        logic [5:0]  successor;
        logic [5:0]  dep_count;
        logic        is_compute;
        logic [31:0] ext_job_id;
        logic        rewind;
        logic        stat_mark;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] ready_task;
        logic       last;
        logic       round_complete;
    } t_res;

    // follow-up work after the decode cycle
    typedef enum logic [1:0] {
        PLAN_FIN   = 2'd0,
        PLAN_READ  = 2'd1,
        PLAN_TDONE = 2'd2,
        PLAN_WALK  = 2'd3
    } t_plan;

    typedef struct packed {
        logic latch;
        logic exec;
        logic read_proc;
        logic walk;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        t_plan plan;
        logic  walk_done;
    } t_dp_stat;

endpackage

// ===== rtl/dcts_ctrl.sv =====
module dcts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  dcts_pkg::t_dp_stat  i_stat,
    output dcts_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_READ  = 5'b00100,
        S_WALK  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    dcts_pkg::t_plan r_plan, n_plan;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_plan  = r_plan;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_plan     = i_stat.plan;
                case (i_stat.plan)
                    dcts_pkg::PLAN_FIN:   n_state = S_FLUSH;
                    dcts_pkg::PLAN_WALK:  n_state = S_WALK;
                    default:              n_state = S_READ;
                endcase
            end
            S_READ: begin
                o_cmd.read_proc = 1'b1;
                n_state = (r_plan == dcts_pkg::PLAN_TDONE) ? S_WALK : S_FLUSH;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plan  <= dcts_pkg::PLAN_FIN;
        end else begin
            r_state <= n_state;
            r_plan  <= n_plan;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/dcts_dp.sv =====
module dcts_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dcts_pkg::t_cmd     i_cmd,
    input  dcts_pkg::t_dp_cmd  i_ctl,
    output dcts_pkg::t_dp_stat o_stat,
    output logic               o_strobe,
    output dcts_pkg::t_res     o_res
);

    localparam int TASKS  = dcts_pkg::TASKS;
    localparam int SLOTS  = dcts_pkg::EXTRA_SLOTS;
    localparam int TIDX_W = dcts_pkg::TIDX_W;
    localparam int SLOT_W = dcts_pkg::SLOT_W;
    localparam int WIDX_W = dcts_pkg::WIDX_W;
    localparam int RDY_W  = dcts_pkg::READY_W;

    // latched item
    dcts_pkg::t_cmd r_item;

    // graph state
    logic [TASKS-1:0] r_loaded, r_nz, r_cvalid, r_rvalid, r_blocked;
    logic [5:0]       mem_total [TASKS];
    logic [5:0]       mem_cnt   [TASKS];
    logic [TASKS-1:0] mem_row   [TASKS];
    logic [5:0]       r_tot_q, r_cnt_q;
    logic             r_tot_v, r_cnt_v, r_row_v;
    logic [TASKS-1:0] r_row_q;
    logic [WIDX_W-1:0] r_done_rem;
    logic [RDY_W-1:0]  r_ready;
    logic [31:0]      r_ids [SLOTS];
    logic [SLOTS-1:0] r_active, r_staged;
    logic             r_fin, r_pend, r_rc;

    // walk pipe
    logic [WIDX_W-1:0] r_widx;
    logic              r_pv;
    logic [TIDX_W-1:0] r_pidx;

    // result staging
    logic           r_hv, r_out_v;
    dcts_pkg::t_res r_hres, r_out;

    // decode
    logic [TIDX_W-1:0] t_i, s_i, widx_i;
    logic              t_oob, s_oob;
    logic [SLOTS-1:0]  match;
    logic              dup, free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              tdone_ok, d_err, d_defer, d_round;
    dcts_pkg::t_plan   d_plan;
    logic              is_round, is_tdone, is_notify;

    assign t_i    = r_item.task_req[TIDX_W-1:0];
    assign s_i    = r_item.successor[TIDX_W-1:0];
    assign widx_i = r_widx[TIDX_W-1:0];
    assign t_oob  = int'(r_item.task_req) >= TASKS;
    assign s_oob  = int'(r_item.successor) >= TASKS;

    assign is_round  = (r_item.action == dcts_pkg::ACT_INST) ||
                       (r_item.action == dcts_pkg::ACT_INST_PEND);
    assign is_tdone  = (r_item.action == dcts_pkg::ACT_TASK_DONE);
    assign is_notify = (r_item.action == dcts_pkg::ACT_NOTIFY);

    // extra dependency slot compare and free slot search
    always_comb begin
        dup        = 1'b0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = (r_ids[i] == r_item.ext_job_id);
        end
        dup = |(r_staged & match);
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!(r_staged[i] || r_active[i])) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign tdone_ok = r_fin && (r_active == '0) && (r_done_rem != '0) &&
                      (r_ready != '0) && !t_oob && r_loaded[t_i];

    // action decode
    always_comb begin
        d_err   = 1'b0;
        d_defer = 1'b0;
        d_round = 1'b0;
        d_plan  = dcts_pkg::PLAN_FIN;
        unique case (r_item.action)
            dcts_pkg::ACT_LOAD_TASK: d_err = r_fin || t_oob;
            dcts_pkg::ACT_LOAD_EDGE: begin
                d_err  = r_fin || t_oob || s_oob;
                d_plan = dcts_pkg::PLAN_READ;
            end
            dcts_pkg::ACT_FINALIZE: d_err = r_fin;
            dcts_pkg::ACT_ADD_EXTRA: d_err = !dup && !free_found;
            dcts_pkg::ACT_INST: begin
                d_err   = !r_fin || r_pend;
                d_defer = (r_done_rem != '0);
                d_round = (r_done_rem == '0);
                d_plan  = d_round ? dcts_pkg::PLAN_WALK : dcts_pkg::PLAN_FIN;
            end
            dcts_pkg::ACT_INST_PEND: begin
                d_err   = !r_fin || !r_pend || (r_done_rem != '0);
                d_round = 1'b1;
                d_plan  = dcts_pkg::PLAN_WALK;
            end
            dcts_pkg::ACT_TASK_DONE: begin
                d_err  = !tdone_ok;
                d_plan = r_item.rewind ? dcts_pkg::PLAN_FIN : dcts_pkg::PLAN_TDONE;
            end
            dcts_pkg::ACT_RECEIVE: begin
                d_err  = !r_fin || t_oob || !r_loaded[t_i];
                d_plan = dcts_pkg::PLAN_READ;
            end
            dcts_pkg::ACT_NOTIFY: begin
                d_err = !r_fin;
                if (!r_item.rewind && (r_active != '0) && ((r_active & ~match) == '0)) begin
                    d_plan = dcts_pkg::PLAN_WALK;
                end
            end
            default: d_err = 1'b1;
        endcase
        if (d_err) begin
            d_plan  = dcts_pkg::PLAN_FIN;
            d_defer = 1'b0;
            d_round = 1'b0;
        end
    end

    assign o_stat.plan      = d_plan;
    assign o_stat.walk_done = (r_widx == WIDX_W'(TASKS)) && !r_pv;

    // per-step processing: receive read-back and walk stage
    logic [5:0]       tot_eff, cnt_eff;
    logic [TASKS-1:0] row_eff;
    logic             rcv_err, walk_issue, w_rowbit, w_cnt_inc;
    logic             blk_set;
    logic [TIDX_W-1:0] blk_idx;
    logic             tot_rd, cnt_rd, row_rd, cnt_we, row_we;
    logic [TIDX_W-1:0] tot_ra, cnt_ra, row_ra, cnt_wa, row_wa;
    logic [5:0]       cnt_wd;
    logic [TASKS-1:0] row_wd;
    logic             e_v;
    dcts_pkg::t_res   e_res;

    assign tot_eff    = r_tot_v ? r_tot_q : 6'd0;
    assign cnt_eff    = r_cnt_v ? r_cnt_q : 6'd0;
    assign row_eff    = r_row_v ? r_row_q : '0;
    assign walk_issue = i_ctl.walk && (r_widx < WIDX_W'(TASKS));
    assign w_rowbit   = row_eff[r_pidx] && r_nz[r_pidx] && r_loaded[r_pidx];

    always_comb begin
        tot_rd = 1'b0; tot_ra = widx_i;
        cnt_rd = 1'b0; cnt_ra = widx_i;
        row_rd = 1'b0; row_ra = t_i;
        cnt_we = 1'b0; cnt_wa = r_pidx; cnt_wd = 6'd0;
        row_we = 1'b0; row_wa = t_i;
        row_wd = row_eff | (TASKS'(1) << s_i);
        rcv_err   = 1'b0;
        w_cnt_inc = 1'b0;
        blk_set   = 1'b0;
        blk_idx   = r_pidx;
        e_v       = 1'b0;
        e_res     = '0;
        // decode cycle: errors, deferral and first reads
        if (i_ctl.exec) begin
            if (d_err) begin
                e_v        = 1'b1;
                e_res.kind = dcts_pkg::KIND_ERR;
            end else if (d_defer) begin
                e_v        = 1'b1;
                e_res.kind = dcts_pkg::KIND_DEFER;
            end else if (r_item.action == dcts_pkg::ACT_LOAD_EDGE) begin
                row_rd = 1'b1;
            end else if (is_tdone && !r_item.rewind) begin
                row_rd = 1'b1;
            end else if (r_item.action == dcts_pkg::ACT_RECEIVE) begin
                cnt_rd = 1'b1;
                cnt_ra = t_i;
            end
        end
        // read-back cycle
        if (i_ctl.read_proc) begin
            if (r_item.action == dcts_pkg::ACT_LOAD_EDGE) begin
                row_we = 1'b1;
            end else if (r_item.action == dcts_pkg::ACT_RECEIVE) begin
                if (cnt_eff == 6'd0) begin
                    rcv_err    = 1'b1;
                    e_v        = 1'b1;
                    e_res.kind = dcts_pkg::KIND_ERR;
                end else begin
                    cnt_we = 1'b1;
                    cnt_wa = t_i;
                    cnt_wd = cnt_eff - 6'd1;
                    if (cnt_eff == 6'd1) begin
                        if (r_active != '0) begin
                            blk_set = 1'b1;
                            blk_idx = t_i;
                        end else begin
                            e_v              = 1'b1;
                            e_res.kind       = dcts_pkg::KIND_READY;
                            e_res.ready_task = 6'(t_i);
                        end
                    end
                end
            end
        end
        // walk: issue read at index, process previous index
        if (walk_issue) begin
            tot_rd = is_round;
            cnt_rd = is_tdone;
        end
        if (i_ctl.walk && r_pv) begin
            if (is_round) begin
                if (r_loaded[r_pidx]) begin
                    cnt_we    = 1'b1;
                    cnt_wd    = tot_eff;
                    w_cnt_inc = 1'b1;
                    if (!r_nz[r_pidx]) begin
                        if (r_active != '0) begin
                            blk_set = 1'b1;
                        end else begin
                            e_v              = 1'b1;
                            e_res.kind       = dcts_pkg::KIND_READY;
                            e_res.ready_task = 6'(r_pidx);
                        end
                    end
                end
            end else if (is_tdone) begin
                if (w_rowbit && (cnt_eff != 6'd0)) begin
                    cnt_we = 1'b1;
                    cnt_wd = cnt_eff - 6'd1;
                    if (cnt_eff == 6'd1) begin
                        e_v                  = 1'b1;
                        e_res.kind           = dcts_pkg::KIND_READY;
                        e_res.ready_task     = 6'(r_pidx);
                        e_res.round_complete = r_rc;
                    end
                end
            end else if (is_notify) begin
                if (r_blocked[r_pidx]) begin
                    e_v              = 1'b1;
                    e_res.kind       = dcts_pkg::KIND_READY;
                    e_res.ready_task = 6'(r_pidx);
                end
            end
        end
    end

    // predecessor totals memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && !d_err && (r_item.action == dcts_pkg::ACT_LOAD_TASK)) begin
            mem_total[t_i] <= r_item.dep_count;
        end
        if (tot_rd) begin
            r_tot_q <= mem_total[tot_ra];
            r_tot_v <= r_loaded[tot_ra];
        end
    end

    // live counters memory
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[cnt_wa] <= cnt_wd;
        end
        if (cnt_rd) begin
            r_cnt_q <= mem_cnt[cnt_ra];
            r_cnt_v <= r_cvalid[cnt_ra];
        end
    end

    // successor rows memory
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            mem_row[row_wa] <= row_wd;
        end
        if (row_rd) begin
            r_row_q <= mem_row[row_ra];
            r_row_v <= r_rvalid[row_ra];
        end
    end

    // item latch and extra id slots
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_item <= i_cmd;
        end
        if (i_ctl.exec && !d_err && !dup && (r_item.action == dcts_pkg::ACT_ADD_EXTRA)) begin
            r_ids[free_idx] <= r_item.ext_job_id;
        end
    end

    // scheduler control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded   <= '0;
            r_nz       <= '0;
            r_cvalid   <= '0;
            r_rvalid   <= '0;
            r_blocked  <= '0;
            r_done_rem <= '0;
            r_ready    <= '0;
            r_active   <= '0;
            r_staged   <= '0;
            r_fin      <= 1'b0;
            r_pend     <= 1'b0;
            r_rc       <= 1'b0;
            r_widx     <= '0;
            r_pv       <= 1'b0;
            r_pidx     <= '0;
        end else begin
            if (cnt_we) begin
                r_cvalid[cnt_wa] <= 1'b1;
            end
            if (row_we) begin
                r_rvalid[row_wa] <= 1'b1;
            end
            if (blk_set) begin
                r_blocked[blk_idx] <= 1'b1;
            end
            if (i_ctl.walk && r_pv && is_notify && r_blocked[r_pidx]) begin
                r_blocked[r_pidx] <= 1'b0;
            end
            // ready count: task done takes one, releases add one each
            if (i_ctl.exec && is_tdone && !d_err) begin
                r_ready <= r_ready - RDY_W'(1);
            end else if (e_v && (e_res.kind == dcts_pkg::KIND_READY) &&
                         (r_ready != dcts_pkg::READY_MAX)) begin
                r_ready <= r_ready + RDY_W'(1);
            end
            if (w_cnt_inc) begin
                r_done_rem <= r_done_rem + WIDX_W'(1);
            end
            // walk index
            if (walk_issue) begin
                r_widx <= r_widx + WIDX_W'(1);
                r_pidx <= widx_i;
                r_pv   <= 1'b1;
            end else begin
                r_pv   <= 1'b0;
            end
            if (i_ctl.exec) begin
                r_widx <= '0;
                r_rc   <= is_tdone && !d_err && (r_done_rem == WIDX_W'(1));
                if (!d_err) begin
                    case (r_item.action)
                        dcts_pkg::ACT_LOAD_TASK: begin
                            r_loaded[t_i] <= 1'b1;
                            r_nz[t_i]     <= (r_item.dep_count != 6'd0);
                        end
                        dcts_pkg::ACT_FINALIZE: r_fin <= 1'b1;
                        dcts_pkg::ACT_ADD_EXTRA: begin
                            if (!dup) begin
                                r_staged[free_idx] <= 1'b1;
                            end
                        end
                        dcts_pkg::ACT_INST: begin
                            if (d_defer) begin
                                r_pend <= 1'b1;
                            end
                        end
                        dcts_pkg::ACT_INST_PEND: r_pend <= 1'b0;
                        dcts_pkg::ACT_TASK_DONE: r_done_rem <= r_done_rem - WIDX_W'(1);
                        dcts_pkg::ACT_NOTIFY: begin
                            if (!r_item.rewind) begin
                                r_staged <= r_staged & ~match;
                                r_active <= r_active & ~match;
                            end
                        end
                        default: ;
                    endcase
                    // new round takes the staged set
                    if (d_round) begin
                        r_active   <= r_staged;
                        r_staged   <= '0;
                        r_blocked  <= '0;
                        r_done_rem <= '0;
                    end
                end
            end
        end
    end

    // one-deep hold so the final beat carries last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            if (i_ctl.flush) begin
                r_out_v <= 1'b1;
                r_hv    <= 1'b0;
                if (r_hv) begin
                    r_out <= '{kind: r_hres.kind, ready_task: r_hres.ready_task,
                               last: 1'b1, round_complete: r_hres.round_complete};
                end else begin
                    r_out <= '{kind: dcts_pkg::KIND_ACK, ready_task: 6'd0,
                               last: 1'b1, round_complete: r_rc};
                end
            end else if (e_v) begin
                if (r_hv) begin
                    r_out_v <= 1'b1;
                    r_out   <= r_hres;
                end
                r_hres <= e_res;
                r_hv   <= 1'b1;
            end
        end
    end

    assign o_strobe = r_out_v;
    assign o_res    = r_out;

    // checks
    a_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.kind != dcts_pkg::KIND_READY)) |-> (r_out.ready_task == 6'd0))
        else $error("non-ready beat carries a task index");
    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx <= WIDX_W'(TASKS))
        else $error("walk index past task count");
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.flush |=> (r_out_v && r_out.last))
        else $error("flush did not give a last beat");
    a_rcv_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rcv_err |-> !r_hv)
        else $error("receive error after an earlier beat");

endmodule

// ===== rtl/dependency_count_task_scheduler.sv =====
// channel   ports                    handshake
// item in   i_cmd (t_cmd)            taken when i_start and !o_busy
// result    o_res (t_res)            valid for one cycle while o_strobe
//
// load, finalize, extra dep, deferral, a rewound task done, notify without release and
// most errors go from decode straight to flush; load edge and receive read memory first.
// instantiate and a releasing notify walk all tasks through the shared memory ports,
// one per cycle, then drain; task done reads its successor row first.
// reset clears all control state at once, no clearing pass.
// results go out one per cycle, the last one as the next item can be taken; no stalls.
module dependency_count_task_scheduler (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  dcts_pkg::t_cmd i_cmd,
    output logic           o_strobe,
    output dcts_pkg::t_res o_res
);

    dcts_pkg::t_dp_cmd  ctl;
    dcts_pkg::t_dp_stat stat;

    dcts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (ctl),
        .o_busy  (o_busy)
    );

    dcts_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule
